// File: rtl/core/tar_header_block_parser_macros.svh
// assertion macros shared by the tar header block parser rtl
`ifndef TAR_HEADER_BLOCK_PARSER_MACROS_SVH
`define TAR_HEADER_BLOCK_PARSER_MACROS_SVH

// same-cycle implication, clocked on clk_i and disabled in reset
`define THBP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i and disabled in reset
`define THBP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/thbp_pkg.sv
// types, constants and offsets of the tar header block parser
package thbp_pkg;

  // block layout
  localparam logic [8:0] BlockLast = 9'd511;
  localparam logic [8:0] NameLen   = 9'd100;
  localparam logic [8:0] ChkStart  = 9'd148;
  localparam logic [8:0] ChkEnd    = 9'd156;
  localparam logic [8:0] TypeOff   = 9'd156;
  localparam logic [8:0] MagicOff  = 9'd257;
  localparam logic [8:0] GnuEnd    = 9'd265;
  localparam logic [8:0] PosixEnd  = 9'd263;
  localparam logic [8:0] StarOff   = 9'd508;
  localparam logic [16:0] TrailerSum = 17'd256;

  // numeric fields: mode, size, mtime, checksum
  localparam int NumFields = 4;
  localparam logic [8:0] FieldStart [NumFields] = '{9'd100, 9'd124, 9'd136, 9'd148};
  localparam logic [8:0] FieldLen   [NumFields] = '{9'd8, 9'd12, 9'd12, 9'd8};
  // fields whose base-256 payload is shorter than eight bytes
  localparam logic [NumFields-1:0] FieldShort = 4'b1001;
  localparam int FldMode = 0;
  localparam int FldSize = 1;
  localparam int FldMtime = 2;
  localparam int FldChk = 3;

  // magic strings
  localparam logic [7:0] GnuMagic [8] = '{8'h75, 8'h73, 8'h74, 8'h61,
                                          8'h72, 8'h20, 8'h20, 8'h00};
  localparam logic [7:0] PosixMagic [6] = '{8'h75, 8'h73, 8'h74, 8'h61, 8'h72, 8'h00};
  localparam logic [7:0] StarMagic [4] = '{8'h74, 8'h61, 8'h72, 8'h00};

  // result codes
  localparam logic [1:0] StatusHeader  = 2'd0;
  localparam logic [1:0] StatusTrailer = 2'd1;
  localparam logic [1:0] StatusBadSize = 2'd2;

  localparam logic [1:0] FmtOld   = 2'd0;
  localparam logic [1:0] FmtPosix = 2'd1;
  localparam logic [1:0] FmtGnu   = 2'd2;
  localparam logic [1:0] FmtStar  = 2'd3;

  localparam logic [1:0] KindRegular = 2'd0;
  localparam logic [1:0] KindDir     = 2'd1;
  localparam logic [1:0] KindSymlink = 2'd2;
  localparam logic [1:0] KindSpecial = 2'd3;

  // parse phase of one numeric field
  typedef enum logic [3:0] {
    PhLead  = 4'd0,
    PhPlus  = 4'd1,
    PhMinus = 4'd2,
    PhDigP  = 4'd3,
    PhDigN  = 4'd4,
    PhDoneP = 4'd5,
    PhDoneN = 4'd6,
    PhB256P = 4'd7,
    PhB256N = 4'd8,
    PhBad   = 4'd9
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [63:0] accum;
  } fld_t;

  // per-block state as seen after the last byte
  typedef struct packed {
    logic [16:0]            sum;
    logic                   chk_zero;
    logic [2:0]             magic;
    logic [7:0]             typeflag;
    logic [7:0]             name_last;
    fld_t [NumFields-1:0]   fld;
  } blk_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [1:0]         format;
    logic [7:0]         typeflag;
    logic [20:0]        file_mode;
    logic signed [63:0] file_size;
    logic signed [63:0] mod_time;
    logic               mtime_valid;
    logic               checksum_ok;
    logic [1:0]         entry_kind;
    logic               is_extension;
    logic               executable;
  } res_t;

endpackage

// File: rtl/core/thbp_if.sv
// valid/ready channel interfaces for input bytes and header results
interface thbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface thbp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [1:0]         format;
  logic [7:0]         typeflag;
  logic [20:0]        file_mode;
  logic signed [63:0] file_size;
  logic signed [63:0] mod_time;
  logic               mtime_valid;
  logic               checksum_ok;
  logic [1:0]         entry_kind;
  logic               is_extension;
  logic               executable;

  modport source (output valid, output status, output format, output typeflag,
                  output file_mode, output file_size, output mod_time,
                  output mtime_valid, output checksum_ok, output entry_kind,
                  output is_extension, output executable, input ready);
  modport sink (input valid, input status, input format, input typeflag,
                input file_mode, input file_size, input mod_time,
                input mtime_valid, input checksum_ok, input entry_kind,
                input is_extension, input executable, output ready);
endinterface

// File: rtl/core/thbp_field_parser.sv
// octal / base-256 parser for one numeric header field, one byte per cycle while en_i is high
module thbp_field_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           clear_i,
  input  logic           en_i,
  input  logic           first_i,
  input  logic [7:0]     byte_i,
  output thbp_pkg::fld_t fld_o
);
  import thbp_pkg::*;

  fld_t fld_q, fld_d;
  logic dig, ws;
  logic [2:0] digit;

  // byte classes
  assign dig   = (byte_i >= 8'h30) && (byte_i <= 8'h37);
  assign digit = byte_i[2:0];
  assign ws    = (byte_i == 8'h20) || ((byte_i >= 8'h09) && (byte_i <= 8'h0d));

  // phase and accumulator update
  always_comb begin
    fld_d = fld_q;
    if (clear_i) begin
      fld_d.phase = PhLead;
      fld_d.accum = '0;
    end else if (en_i) begin
      if (first_i && byte_i[7]) begin
        if (byte_i == 8'h80) fld_d.phase = PhB256P;
        else if (byte_i == 8'hff) fld_d.phase = PhB256N;
        else fld_d.phase = PhBad;
      end else begin
        case (fld_q.phase)
          PhLead: begin
            if (ws) fld_d.phase = PhLead;
            else if (byte_i == 8'h2b) fld_d.phase = PhPlus;
            else if (byte_i == 8'h2d) fld_d.phase = PhMinus;
            else if (dig) begin
              fld_d.accum = {61'b0, digit};
              fld_d.phase = PhDigP;
            end else fld_d.phase = PhDoneP;
          end
          PhPlus, PhMinus: begin
            if (dig) begin
              fld_d.accum = {61'b0, digit};
              fld_d.phase = (fld_q.phase == PhPlus) ? PhDigP : PhDigN;
            end else fld_d.phase = PhDoneP;
          end
          PhDigP, PhDigN: begin
            if (dig) fld_d.accum = {fld_q.accum[60:0], digit};
            else fld_d.phase = (fld_q.phase == PhDigP) ? PhDoneP : PhDoneN;
          end
          PhB256P, PhB256N: begin
            fld_d.accum = {fld_q.accum[55:0], byte_i};
          end
          default: begin
            fld_d = fld_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fld_q.phase <= PhLead;
      fld_q.accum <= '0;
    end else begin
      fld_q <= fld_d;
    end
  end

  assign fld_o = fld_q;

endmodule

// File: rtl/core/thbp_result.sv
// final field values, format and entry classification of one header block
module thbp_result (
  input  thbp_pkg::blk_t blk_i,
  output thbp_pkg::res_t res_o
);
  import thbp_pkg::*;

  logic [63:0] val [NumFields];
  logic [NumFields-1:0] ok;
  logic [1:0] fmt;
  logic [1:0] kind;
  logic [7:0] t;

  // value of each field from its final phase
  always_comb begin
    for (int j = 0; j < NumFields; j++) begin
      ok[j]  = 1'b1;
      val[j] = '0;
      case (blk_i.fld[j].phase)
        PhBad: ok[j] = 1'b0;
        PhDigN, PhDoneN: val[j] = 64'd0 - blk_i.fld[j].accum;
        PhB256N: begin
          if (FieldShort[j] && blk_i.fld[j].accum[55]) begin
            val[j] = {8'hff, blk_i.fld[j].accum[55:0]};
          end else begin
            val[j] = blk_i.fld[j].accum;
          end
        end
        PhDigP, PhDoneP, PhB256P: val[j] = blk_i.fld[j].accum;
        default: val[j] = '0;
      endcase
    end
  end

  // magic priority: gnu, posix, star
  always_comb begin
    if (blk_i.magic[0]) fmt = FmtGnu;
    else if (blk_i.magic[1]) fmt = FmtPosix;
    else if (blk_i.magic[2]) fmt = FmtStar;
    else fmt = FmtOld;
  end

  // entry classification
  assign t = blk_i.typeflag;
  always_comb begin
    if (t == 8'h32) begin
      kind = KindSymlink;
    end else if ((fmt == FmtPosix) || (fmt == FmtStar)) begin
      if ((t == 8'h30) || (t == 8'h00)) kind = KindRegular;
      else if (t == 8'h35) kind = KindDir;
      else kind = KindSpecial;
    end else if (fmt == FmtGnu) begin
      if ((t == 8'h30) || (t == 8'h37) || (t == 8'h00)) kind = KindRegular;
      else if (t == 8'h35) kind = KindDir;
      else kind = KindSpecial;
    end else begin
      if (blk_i.name_last == 8'h2f) kind = KindDir;
      else if ((t == 8'h00) || (t == 8'h30)) kind = KindRegular;
      else kind = KindSpecial;
    end
  end

  // result assembly
  always_comb begin
    res_o = '0;
    if ((blk_i.sum == TrailerSum) && blk_i.chk_zero) begin
      res_o.status = StatusTrailer;
    end else begin
      res_o.status       = ok[FldSize] ? StatusHeader : StatusBadSize;
      res_o.format       = fmt;
      res_o.typeflag     = t;
      res_o.file_mode    = val[FldMode][20:0];
      res_o.entry_kind   = kind;
      res_o.is_extension = (t == 8'h4c) || (t == 8'h4b) || (t == 8'h78) ||
                           (t == 8'h58) || (t == 8'h67);
      res_o.executable   = val[FldMode][0] | val[FldMode][3] | val[FldMode][6];
      if (ok[FldSize]) begin
        res_o.file_size   = val[FldSize];
        res_o.mod_time    = ok[FldMtime] ? val[FldMtime] : 64'sd0;
        res_o.mtime_valid = ok[FldMtime];
        res_o.checksum_ok = (val[FldChk] == {47'b0, blk_i.sum});
      end
    end
  end

endmodule

// File: rtl/core/tar_header_block_parser.sv
// tar header block parser top level
//
// in_i carries the archive one byte per transfer; every 512 bytes form one
// header block. res_o gives exactly one result per block, after its last
// byte: parsed header, all-zero trailer block, or unparsable size field.
// An accepted byte lands in an input register and is folded into the block
// state when the update stage advances; the result of a block is loaded into
// the result register as its last byte leaves the input register. One byte
// per cycle is sustained, set by the update of the block state and the four
// field parsers, unless a stalled result holds the last byte of a block.
// Reset clears the byte counter, the running sum, the magic candidates and
// all field parsers; no clearing pass follows, so in_i is ready at once.
// A stalled res_o holds its result; bytes keep flowing until the last byte
// of the next block reaches the update stage, which then waits until the
// pending result is transferred, and in_i drops ready behind it.
module tar_header_block_parser (
  input logic        clk_i,
  input logic        rst_ni,
  thbp_in_if.sink    in_i,
  thbp_out_if.source res_o
);
  import thbp_pkg::*;
  `include "tar_header_block_parser_macros.svh"

  logic [7:0]  byte_q;
  logic        vld_q;
  logic [8:0]  idx_q, idx_d;
  logic [16:0] sum_q, sum_upd;
  logic        chk_zero_q, chk_zero_upd;
  logic [2:0]  magic_q, magic_upd;
  logic [7:0]  type_q, type_upd;
  logic [7:0]  name_last_q, name_last_upd;
  logic        name_ended_q, name_ended_upd;
  logic        last, adv, adv_last, in_chk;
  logic [8:0]  moff;
  fld_t [NumFields-1:0] fld_w;
  logic [NumFields-1:0] fld_en, fld_first;
  blk_t        blk;
  res_t        res_d, res_q;
  logic        res_valid_q;

  // stage control
  assign last     = (idx_q == BlockLast);
  assign adv      = vld_q && (!last || !res_valid_q || res_o.ready);
  assign adv_last = adv && last;
  assign in_i.ready = !vld_q || adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_i.ready) begin
      vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      byte_q <= in_i.data_byte;
    end
  end

  // block state update for the byte in the input register
  assign in_chk = (idx_q >= ChkStart) && (idx_q < ChkEnd);
  assign moff   = idx_q - MagicOff;

  always_comb begin
    sum_upd        = sum_q + (in_chk ? 17'd32 : {9'b0, byte_q});
    chk_zero_upd   = chk_zero_q && !(in_chk && (byte_q != 8'h00));
    name_last_upd  = name_last_q;
    name_ended_upd = name_ended_q;
    if ((idx_q < NameLen) && !name_ended_q) begin
      if (byte_q == 8'h00) name_ended_upd = 1'b1;
      else name_last_upd = byte_q;
    end
    type_upd  = (idx_q == TypeOff) ? byte_q : type_q;
    magic_upd = magic_q;
    if ((idx_q >= MagicOff) && (idx_q < GnuEnd) && (byte_q != GnuMagic[moff[2:0]])) begin
      magic_upd[0] = 1'b0;
    end
    if ((idx_q >= MagicOff) && (idx_q < PosixEnd) &&
        (byte_q != PosixMagic[moff[2:0]])) begin
      magic_upd[1] = 1'b0;
    end
    if ((idx_q >= StarOff) && (byte_q != StarMagic[idx_q[1:0]])) begin
      magic_upd[2] = 1'b0;
    end
  end

  assign idx_d = last ? '0 : idx_q + 9'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      sum_q        <= '0;
      chk_zero_q   <= 1'b1;
      magic_q      <= 3'b111;
      type_q       <= '0;
      name_last_q  <= '0;
      name_ended_q <= 1'b0;
    end else if (adv_last) begin
      idx_q        <= '0;
      sum_q        <= '0;
      chk_zero_q   <= 1'b1;
      magic_q      <= 3'b111;
      type_q       <= '0;
      name_last_q  <= '0;
      name_ended_q <= 1'b0;
    end else if (adv) begin
      idx_q        <= idx_d;
      sum_q        <= sum_upd;
      chk_zero_q   <= chk_zero_upd;
      magic_q      <= magic_upd;
      type_q       <= type_upd;
      name_last_q  <= name_last_upd;
      name_ended_q <= name_ended_upd;
    end
  end

  // numeric field parsers
  for (genvar j = 0; j < NumFields; j++) begin : g_fld
    assign fld_en[j]    = adv && (idx_q >= FieldStart[j]) &&
                          (idx_q < FieldStart[j] + FieldLen[j]);
    assign fld_first[j] = (idx_q == FieldStart[j]);

    thbp_field_parser u_fld (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clear_i (adv_last),
      .en_i    (fld_en[j]),
      .first_i (fld_first[j]),
      .byte_i  (byte_q),
      .fld_o   (fld_w[j])
    );
  end

  // block summary including the last byte
  always_comb begin
    blk.sum       = sum_upd;
    blk.chk_zero  = chk_zero_upd;
    blk.magic     = magic_upd;
    blk.typeflag  = type_upd;
    blk.name_last = name_last_upd;
    blk.fld       = fld_w;
  end

  thbp_result u_result (
    .blk_i (blk),
    .res_o (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (adv_last) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_last) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.status       = res_q.status;
  assign res_o.format       = res_q.format;
  assign res_o.typeflag     = res_q.typeflag;
  assign res_o.file_mode    = res_q.file_mode;
  assign res_o.file_size    = res_q.file_size;
  assign res_o.mod_time     = res_q.mod_time;
  assign res_o.mtime_valid  = res_q.mtime_valid;
  assign res_o.checksum_ok  = res_q.checksum_ok;
  assign res_o.entry_kind   = res_q.entry_kind;
  assign res_o.is_extension = res_q.is_extension;
  assign res_o.executable   = res_q.executable;

  // checks
  `THBP_ASSERT_NXT(a_last_gives_result, adv_last, res_valid_q,
                   "last byte of a block did not load a result")
  `THBP_ASSERT_IMP(a_result_from_last, $rose(res_valid_q), $past(adv_last),
                   "result appeared without a finished block")
  `THBP_ASSERT_IMP(a_clear_at_start, idx_q == '0,
                   (sum_q == '0) && chk_zero_q && (magic_q == 3'b111),
                   "block state not cleared at block start")
  `THBP_ASSERT_NXT(a_last_held, vld_q && last && res_valid_q && !res_o.ready,
                   vld_q && last,
                   "last byte lost while result stalled")

endmodule
